// ----- src/assert_macros.svh -----
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante in one cycle forces cons in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/sft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sft_pkg;

  localparam int POS_W = 36;
  localparam int VEL_W = 32;
  localparam int OUT_W = 32;
  localparam int COSINE_FRACTION_BITS = 30;
  localparam int RATE_FRACTION_BITS = 48;

  localparam int PROD_W = POS_W + VEL_W;
  localparam int H_W = PROD_W + 1;
  localparam int MAG_W = H_W + POS_W + 1;
  localparam int BIG_W = 2 * MAG_W + 2 * RATE_FRACTION_BITS + 4;

  localparam int QUO_W = 2 * OUT_W + 2;
  localparam int ROT_SHIFT = 2 * COSINE_FRACTION_BITS + 2;
  localparam int RATE_SHIFT = 2 * RATE_FRACTION_BITS + 2;
  localparam int RATE_SCALE = 1000000;

  localparam logic [63:0] ROT_LIM = 64'd1 << COSINE_FRACTION_BITS;
  localparam logic [63:0] COUP_LIM = 64'h0000_0000_8000_0000;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_END = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              row_index;
    logic signed [OUT_W-1:0] rot_col0;
    logic signed [OUT_W-1:0] rot_col1;
    logic signed [OUT_W-1:0] rot_col2;
    logic signed [OUT_W-1:0] coup_col0;
    logic signed [OUT_W-1:0] coup_col1;
    logic signed [OUT_W-1:0] coup_col2;
    logic                    degenerate;
    logic                    last_row;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] r0;
    logic signed [POS_W-1:0] r1;
    logic signed [POS_W-1:0] r2;
    logic signed [H_W-1:0]   h0;
    logic signed [H_W-1:0]   h1;
    logic signed [H_W-1:0]   h2;
    logic                    degen;
  } q_entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] dst;
    logic [3:0] src_a;
    logic [3:0] src_b;
    logic       clr;
    logic       sub;
    logic       wide;
    logic [3:0] sgn_sel;
    logic       sgn_inv;
    logic       coup;
    logic [4:0] slot;
  } uop_t;

  // convert magnitude to signed output code with saturation
  function automatic logic [OUT_W-1:0] encode(input logic neg, input logic [63:0] q);
    logic [63:0] m;
    m = (q > 64'h0000_0000_8000_0000) ? 64'h0000_0000_8000_0000 : q;
    if (q == 64'd0) begin
      return '0;
    end else if (neg) begin
      return OUT_W'(64'd0 - m);
    end else begin
      return (q > 64'h0000_0000_7FFF_FFFF) ? OUT_W'(64'h7FFF_FFFF) : q[OUT_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/sft_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sft_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire sft_pkg::in_item_t   in_data,
  input  wire logic [sft_pkg::Q_CNT_W-1:0] q_count,
  output logic                     busy,
  output logic                     push,
  output sft_pkg::q_entry_t        push_data
);

  logic s1_valid_r;
  logic signed [sft_pkg::POS_W-1:0] r_r [3];
  logic signed [sft_pkg::PROD_W-1:0] p_r [6];
  logic [sft_pkg::Q_CNT_W:0] used;
  logic accept;
  logic signed [sft_pkg::H_W-1:0] h0, h1, h2;

  // reserve a queue slot for the item held in the product stage
  assign used = {1'b0, q_count} + (sft_pkg::Q_CNT_W + 1)'(s1_valid_r);
  assign busy = used >= (sft_pkg::Q_CNT_W + 1)'(sft_pkg::Q_DEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_r[0] <= in_data.pos_x;
      r_r[1] <= in_data.pos_y;
      r_r[2] <= in_data.pos_z;
      p_r[0] <= sft_pkg::PROD_W'(in_data.pos_y) * sft_pkg::PROD_W'(in_data.vel_z);
      p_r[1] <= sft_pkg::PROD_W'(in_data.pos_z) * sft_pkg::PROD_W'(in_data.vel_y);
      p_r[2] <= sft_pkg::PROD_W'(in_data.pos_z) * sft_pkg::PROD_W'(in_data.vel_x);
      p_r[3] <= sft_pkg::PROD_W'(in_data.pos_x) * sft_pkg::PROD_W'(in_data.vel_z);
      p_r[4] <= sft_pkg::PROD_W'(in_data.pos_x) * sft_pkg::PROD_W'(in_data.vel_y);
      p_r[5] <= sft_pkg::PROD_W'(in_data.pos_y) * sft_pkg::PROD_W'(in_data.vel_x);
    end
  end

  assign h0 = sft_pkg::H_W'(p_r[0]) - sft_pkg::H_W'(p_r[1]);
  assign h1 = sft_pkg::H_W'(p_r[2]) - sft_pkg::H_W'(p_r[3]);
  assign h2 = sft_pkg::H_W'(p_r[4]) - sft_pkg::H_W'(p_r[5]);

  assign push = s1_valid_r;
  always_comb begin
    push_data.r0 = r_r[0];
    push_data.r1 = r_r[1];
    push_data.r2 = r_r[2];
    push_data.h0 = h0;
    push_data.h1 = h1;
    push_data.h2 = h2;
    // zero position or velocity along it: no frame can be built
    push_data.degen = ((r_r[0] == '0) && (r_r[1] == '0) && (r_r[2] == '0)) ||
                      ((h0 == '0) && (h1 == '0) && (h2 == '0));
  end

endmodule
`default_nettype wire

// ----- src/sft_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sft_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sft_pkg::q_entry_t push_data,
  input  wire logic              pop,
  output logic                   q_valid,
  output sft_pkg::q_entry_t      q_head,
  output logic [sft_pkg::Q_CNT_W-1:0] q_count
);

  sft_pkg::q_entry_t q_mem [sft_pkg::Q_DEPTH];
  logic [sft_pkg::Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sft_pkg::Q_CNT_W-1:0] count_r;
  logic full;

  assign full = count_r == sft_pkg::Q_CNT_W'(sft_pkg::Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_head = q_mem[rd_ptr_r];
  assign q_count = count_r;

  // depth is a power of two, so pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= push_data;
  end

  `ASSERT_NEVER(a_no_overflow, push && full && !pop, "queue push while full")
  `ASSERT_NEVER(a_no_underflow, pop && (count_r == '0), "queue pop while empty")
  `ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "queue count slip")

endmodule
`default_nettype wire

// ----- src/sft_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sft_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire sft_pkg::q_entry_t q_head,
  output logic                   pop,
  output logic                   out_valid,
  output sft_pkg::out_item_t     out_data
);

  localparam int PC_W = 6;
  localparam int RF_DEPTH = 16;
  localparam int RES_N = 18;
  localparam int ROW_N = 6;
  localparam int SGN_N = 9;
  localparam int DV_CW = $clog2(sft_pkg::QUO_W + 1);

  // register file codes; r, h and w codes double as sign indexes
  localparam logic [3:0] RG_R0 = 4'd0;
  localparam logic [3:0] RG_H0 = 4'd3;
  localparam logic [3:0] RG_W0 = 4'd6;
  localparam logic [3:0] RG_NR = 4'd9;
  localparam logic [3:0] RG_NH = 4'd10;
  localparam logic [3:0] RG_NW = 4'd11;
  localparam logic [3:0] RG_DR = 4'd12;
  localparam logic [3:0] RG_T = 4'd13;
  localparam logic [3:0] RG_T2 = 4'd14;
  localparam logic [3:0] RG_K = 4'd15;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_MUL = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;
  localparam logic [2:0] ST_SQRT = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  localparam logic [2:0] LD_LAST = 3'd6;
  localparam logic [sft_pkg::QUO_W-1:0] SQ_ONE_INIT =
    sft_pkg::QUO_W'(1) << (sft_pkg::QUO_W - 2);

  function automatic sft_pkg::uop_t mul_op(input logic [3:0] dst, input logic [3:0] a,
                                           input logic [3:0] b, input logic clr,
                                           input logic sub);
    sft_pkg::uop_t u;
    u = '0;
    u.op = sft_pkg::OP_MUL;
    u.dst = dst;
    u.src_a = a;
    u.src_b = b;
    u.clr = clr;
    u.sub = sub;
    return u;
  endfunction

  function automatic sft_pkg::uop_t div_op(input logic [3:0] num, input logic [3:0] den,
                                           input logic wide, input logic [3:0] sgn,
                                           input logic inv, input logic coup,
                                           input logic [4:0] slot);
    sft_pkg::uop_t u;
    u = '0;
    u.op = sft_pkg::OP_DIV;
    u.src_a = num;
    u.src_b = den;
    u.wide = wide;
    u.sgn_sel = sgn;
    u.sgn_inv = inv;
    u.coup = coup;
    u.slot = slot;
    return u;
  endfunction

  // result slots: row * 6, then rot columns, then coupling columns
  function automatic sft_pkg::uop_t ucode(input logic [PC_W-1:0] pc);
    sft_pkg::uop_t u;
    logic [PC_W-1:0] k;
    logic [1:0] j;
    logic [3:0] rj, hj, wj;
    logic [4:0] cj;
    u = '0;
    u.op = sft_pkg::OP_END;
    if (pc < PC_W'(25)) begin
      j = 2'd0;
      k = pc - PC_W'(16);
    end else if (pc < PC_W'(34)) begin
      j = 2'd1;
      k = pc - PC_W'(25);
    end else begin
      j = 2'd2;
      k = pc - PC_W'(34);
    end
    rj = RG_R0 + 4'(j);
    hj = RG_H0 + 4'(j);
    wj = RG_W0 + 4'(j);
    cj = 5'(j);
    if (pc < PC_W'(16)) begin
      case (pc)
        6'd0:  u = mul_op(RG_W0, RG_H0 + 4'd1, RG_R0 + 4'd2, 1'b1, 1'b0);
        6'd1:  u = mul_op(RG_W0, RG_H0 + 4'd2, RG_R0 + 4'd1, 1'b0, 1'b1);
        6'd2:  u = mul_op(RG_W0 + 4'd1, RG_H0 + 4'd2, RG_R0, 1'b1, 1'b0);
        6'd3:  u = mul_op(RG_W0 + 4'd1, RG_H0, RG_R0 + 4'd2, 1'b0, 1'b1);
        6'd4:  u = mul_op(RG_W0 + 4'd2, RG_H0, RG_R0 + 4'd1, 1'b1, 1'b0);
        6'd5:  u = mul_op(RG_W0 + 4'd2, RG_H0 + 4'd1, RG_R0, 1'b0, 1'b1);
        6'd6:  u = mul_op(RG_NR, RG_R0, RG_R0, 1'b1, 1'b0);
        6'd7:  u = mul_op(RG_NR, RG_R0 + 4'd1, RG_R0 + 4'd1, 1'b0, 1'b0);
        6'd8:  u = mul_op(RG_NR, RG_R0 + 4'd2, RG_R0 + 4'd2, 1'b0, 1'b0);
        6'd9:  u = mul_op(RG_NH, RG_H0, RG_H0, 1'b1, 1'b0);
        6'd10: u = mul_op(RG_NH, RG_H0 + 4'd1, RG_H0 + 4'd1, 1'b0, 1'b0);
        6'd11: u = mul_op(RG_NH, RG_H0 + 4'd2, RG_H0 + 4'd2, 1'b0, 1'b0);
        6'd12: u = mul_op(RG_NW, RG_NR, RG_NH, 1'b1, 1'b0);
        6'd13: u = mul_op(RG_T, RG_NR, RG_NR, 1'b1, 1'b0);
        6'd14: u = mul_op(RG_T, RG_T, RG_NR, 1'b1, 1'b0);
        default: u = mul_op(RG_DR, RG_T, RG_K, 1'b1, 1'b0);
      endcase
    end else if (pc < PC_W'(43)) begin
      case (k)
        6'd0: u = mul_op(RG_T, rj, rj, 1'b1, 1'b0);
        6'd1: u = div_op(RG_T, RG_NR, 1'b0, rj, 1'b0, 1'b0, cj);
        6'd2: u = mul_op(RG_T2, RG_T, RG_NH, 1'b1, 1'b0);
        6'd3: u = div_op(RG_T2, RG_DR, 1'b1, rj, 1'b1, 1'b1, 5'd9 + cj);
        6'd4: u = mul_op(RG_T, hj, hj, 1'b1, 1'b0);
        6'd5: u = div_op(RG_T, RG_NH, 1'b0, hj, 1'b0, 1'b0, 5'd12 + cj);
        6'd6: u = mul_op(RG_T, wj, wj, 1'b1, 1'b0);
        6'd7: u = div_op(RG_T, RG_NW, 1'b0, wj, 1'b0, 1'b0, 5'd6 + cj);
        default: u = div_op(RG_T, RG_DR, 1'b1, wj, 1'b0, 1'b1, 5'd3 + cj);
      endcase
    end
    return u;
  endfunction

  logic [2:0] state_r;
  logic [PC_W-1:0] pc_r;
  logic [2:0] ld_r;
  logic [1:0] em_r;
  logic [DV_CW-1:0] dv_cnt_r;
  logic ovf_r;
  logic degen_r;
  logic [SGN_N-1:0] sg_r;
  logic out_valid_r;
  sft_pkg::out_item_t out_r;

  logic signed [sft_pkg::BIG_W-1:0] rf_mem [RF_DEPTH];
  logic signed [sft_pkg::BIG_W-1:0] rd_a_r, rd_b_r;
  logic signed [sft_pkg::BIG_W-1:0] macc_r, ma_r;
  logic [sft_pkg::BIG_W-1:0] mb_r;
  logic msub_r;
  logic [sft_pkg::BIG_W-1:0] dv_rem_r, dv_den_r;
  logic [sft_pkg::QUO_W-1:0] quo_r, sq_op_r, sq_res_r, sq_one_r;
  logic [sft_pkg::OUT_W-1:0] res_r [RES_N];

  sft_pkg::uop_t cur;
  logic wr_en;
  logic [3:0] wr_addr;
  logic signed [sft_pkg::BIG_W-1:0] wr_data;
  logic dv_ge;
  logic [sft_pkg::QUO_W-1:0] sq_try;
  logic [63:0] q_round, q_lim, q_final;
  logic [sft_pkg::OUT_W-1:0] enc_val;

  assign cur = ucode(pc_r);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = cur.dst;
    wr_data = macc_r;
    if (state_r == ST_LOAD) begin
      wr_en = 1'b1;
      wr_addr = (ld_r == LD_LAST) ? RG_K : 4'(ld_r);
      case (ld_r)
        3'd0: wr_data = sft_pkg::BIG_W'(q_head.r0);
        3'd1: wr_data = sft_pkg::BIG_W'(q_head.r1);
        3'd2: wr_data = sft_pkg::BIG_W'(q_head.r2);
        3'd3: wr_data = sft_pkg::BIG_W'(q_head.h0);
        3'd4: wr_data = sft_pkg::BIG_W'(q_head.h1);
        3'd5: wr_data = sft_pkg::BIG_W'(q_head.h2);
        default: wr_data = sft_pkg::BIG_W'(sft_pkg::RATE_SCALE);
      endcase
    end else if ((state_r == ST_MUL) && (mb_r == '0)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rf_mem[wr_addr] <= wr_data;
    rd_a_r <= rf_mem[cur.src_a];
    rd_b_r <= rf_mem[cur.src_b];
  end

  assign dv_ge = dv_rem_r >= dv_den_r;
  assign sq_try = sq_res_r + sq_one_r;
  // nearest integer ties up: q = (isqrt(floor(N/D)) + 1) / 2
  assign q_round = (64'(sq_res_r) + 64'd1) >> 1;
  assign q_lim = cur.coup ? sft_pkg::COUP_LIM : sft_pkg::ROT_LIM;
  assign q_final = (ovf_r || (q_round > q_lim)) ? q_lim : q_round;
  assign enc_val = sft_pkg::encode(sg_r[cur.sgn_sel] ^ cur.sgn_inv, q_final);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
      ld_r <= '0;
      em_r <= '0;
      dv_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            ld_r <= '0;
            em_r <= '0;
            pc_r <= '0;
            state_r <= q_head.degen ? ST_EMIT : ST_LOAD;
          end
        end
        ST_LOAD: begin
          ld_r <= ld_r + 3'd1;
          if (ld_r == LD_LAST) state_r <= ST_FETCH;
        end
        ST_FETCH: begin
          state_r <= (cur.op == sft_pkg::OP_END) ? ST_EMIT : ST_SETUP;
        end
        ST_SETUP: begin
          dv_cnt_r <= '0;
          state_r <= (cur.op == sft_pkg::OP_MUL) ? ST_MUL : ST_DIV;
        end
        ST_MUL: begin
          if (mb_r == '0) begin
            pc_r <= pc_r + 1'b1;
            state_r <= ST_FETCH;
          end
        end
        ST_DIV: begin
          dv_cnt_r <= dv_cnt_r + 1'b1;
          if (dv_cnt_r == DV_CW'(sft_pkg::QUO_W)) state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_one_r == '0) begin
            pc_r <= pc_r + 1'b1;
            state_r <= ST_FETCH;
          end
        end
        default: begin
          out_valid_r <= 1'b1;
          em_r <= em_r + 2'd1;
          if (em_r == 2'd2) state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        degen_r <= q_head.degen;
        sg_r[0] <= q_head.r0[sft_pkg::POS_W-1];
        sg_r[1] <= q_head.r1[sft_pkg::POS_W-1];
        sg_r[2] <= q_head.r2[sft_pkg::POS_W-1];
        sg_r[3] <= q_head.h0[sft_pkg::H_W-1];
        sg_r[4] <= q_head.h1[sft_pkg::H_W-1];
        sg_r[5] <= q_head.h2[sft_pkg::H_W-1];
        for (int i = 0; i < RES_N; i++) res_r[i] <= '0;
      end
      ST_SETUP: begin
        ma_r <= rd_a_r;
        mb_r <= rd_b_r[sft_pkg::BIG_W-1] ? $unsigned(-rd_b_r) : $unsigned(rd_b_r);
        msub_r <= cur.sub ^ rd_b_r[sft_pkg::BIG_W-1];
        if (cur.clr) macc_r <= '0;
        dv_rem_r <= cur.wide ? ($unsigned(rd_a_r) << sft_pkg::RATE_SHIFT)
                             : ($unsigned(rd_a_r) << sft_pkg::ROT_SHIFT);
        dv_den_r <= $unsigned(rd_b_r) << sft_pkg::QUO_W;
        quo_r <= '0;
        sq_res_r <= '0;
        sq_one_r <= SQ_ONE_INIT;
      end
      ST_MUL: begin
        if (mb_r == '0) begin
          if (cur.dst < 4'(SGN_N)) sg_r[cur.dst] <= macc_r[sft_pkg::BIG_W-1];
        end else begin
          if (mb_r[0]) macc_r <= msub_r ? (macc_r - ma_r) : (macc_r + ma_r);
          ma_r <= ma_r <<< 1;
          mb_r <= mb_r >> 1;
        end
      end
      ST_DIV: begin
        dv_den_r <= dv_den_r >> 1;
        if (dv_cnt_r == '0) begin
          ovf_r <= dv_ge;
        end else begin
          if (dv_ge) dv_rem_r <= dv_rem_r - dv_den_r;
          quo_r <= {quo_r[sft_pkg::QUO_W-2:0], dv_ge};
          sq_op_r <= {quo_r[sft_pkg::QUO_W-2:0], dv_ge};
        end
      end
      ST_SQRT: begin
        if (sq_one_r == '0) begin
          res_r[cur.slot] <= enc_val;
        end else begin
          if (sq_op_r >= sq_try) begin
            sq_op_r <= sq_op_r - sq_try;
            sq_res_r <= (sq_res_r >> 1) + sq_one_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_one_r <= sq_one_r >> 2;
        end
      end
      ST_EMIT: begin
        out_r.row_index <= em_r;
        out_r.rot_col0 <= $signed(res_r[0]);
        out_r.rot_col1 <= $signed(res_r[1]);
        out_r.rot_col2 <= $signed(res_r[2]);
        out_r.coup_col0 <= $signed(res_r[3]);
        out_r.coup_col1 <= $signed(res_r[4]);
        out_r.coup_col2 <= $signed(res_r[5]);
        out_r.degenerate <= degen_r;
        out_r.last_row <= em_r == 2'd2;
        // advance the next row into the output slots
        for (int i = 0; i < RES_N - ROW_N; i++) res_r[i] <= res_r[i + ROW_N];
        for (int i = RES_N - ROW_N; i < RES_N; i++) res_r[i] <= '0;
      end
      default: begin
      end
    endcase
  end

  assign pop = (state_r == ST_EMIT) && (em_r == 2'd2);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// ----- src/synodic_frame_state_transform.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Each state runs 28 products, each fetched, set up and then shifted and added over the
// multiplier bits, and 15 elements, each fetched, set up, divided and square-rooted; a
// degenerate state skips them and goes straight to its rows. The three rows leave on
// consecutive cycles; the sequencer works on one state at a time while one more waits
// in the buffer. The receiver cannot stall. Reset empties the buffer and returns the
// sequencer to idle.
module synodic_frame_state_transform (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sft_pkg::in_item_t  in_data,
  output logic                    out_valid,
  output sft_pkg::out_item_t      out_data
);

  logic push, pop, q_valid;
  sft_pkg::q_entry_t push_data, q_head;
  logic [sft_pkg::Q_CNT_W-1:0] q_count;

  sft_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .q_count(q_count), .busy(busy), .push(push), .push_data(push_data)
  );

  sft_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .pop(pop),
    .q_valid(q_valid), .q_head(q_head), .q_count(q_count)
  );

  sft_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire
